// ===== rtl/vmx_pkg.sv =====
// Shared types and constants of the voice mixer.
package vmx_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 16;
  localparam int LEN_W      = 17;
  localparam int VNUM_W     = 5;
  localparam int VOL_W      = 16;
  localparam int UNITY_GAIN = 32768;
  localparam int VOL_RESET  = 16384;
  localparam int FRAC_W     = 15;

  // Input actions; code 3 means nothing and is served by default arms.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_TICK  = 2'd2
  } vmx_action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_SCAN,
    ST_TICK,
    ST_SCALE,
    ST_DONE
  } vmx_state_t;

  typedef struct packed {
    logic [1:0]                 action;
    logic [ADDR_W-1:0]          address;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [LEN_W-1:0]           length;
  } vmx_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic [VNUM_W-1:0]          voice_number;
    logic                       no_free_voice;
  } vmx_out_t;

endpackage

// ===== rtl/vmx_addr_reduce.sv =====
// Reduction of a 16-bit address modulo the sample memory depth by reciprocal multiplication.
module vmx_addr_reduce #(
  parameter int SAMPLE_MEM_DEPTH = 65536,
  parameter int AW               = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vmx_pkg::ADDR_W-1:0] addr,
  output logic                       done,
  output logic [AW-1:0]              rem
);
  import vmx_pkg::*;

  // The quotient (addr * RECIP) >> SHIFT is exact for every 16-bit address when SHIFT is
  // the address width plus ceil(log2(depth)) and RECIP is 2^SHIFT / depth rounded up.
  localparam int     LOG_D = $clog2(SAMPLE_MEM_DEPTH);
  localparam int     SHIFT = ADDR_W + LOG_D;
  localparam int     RW    = ADDR_W + 2;
  localparam int     PW    = ADDR_W + RW;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(SAMPLE_MEM_DEPTH) - 1) /
                             longint'(SAMPLE_MEM_DEPTH);
  localparam logic [RW-1:0]     RECIP_C  = RW'(RECIP);
  localparam logic [ADDR_W-1:0] DEPTH_LO = ADDR_W'(SAMPLE_MEM_DEPTH);

  logic              s1_r, done_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [ADDR_W-1:0] quo;
  logic [ADDR_W-1:0] rem_lo;
  logic [AW-1:0]     rem_r, rem_nxt;

  // Multiply the address by the reciprocal of the depth into the product register.
  assign prod_nxt = PW'(addr) * PW'(RECIP_C);

  // From the product register: the remainder fits the address width, so modular arithmetic is exact.
  assign quo     = ADDR_W'(prod_r >> SHIFT);
  assign rem_lo  = addr_r - ADDR_W'(quo * DEPTH_LO);
  assign rem_nxt = AW'(rem_lo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      done_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
      addr_r <= addr;
    end
    if (s1_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/vmx_scale_clip.sv =====
// Master volume multiply, floor to Q1.15 and saturation, two register stages.
module vmx_scale_clip #(
  parameter int SW = 22
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [SW-1:0]                sum,
  input  logic [vmx_pkg::VOL_W-1:0]           vol,
  output logic                                done,
  output logic signed [vmx_pkg::SAMPLE_W-1:0] mix
);
  import vmx_pkg::*;

  localparam int PW = SW + VOL_W + 1;
  localparam logic signed [PW-1:0] Q_MAX = PW'(32767);
  localparam logic signed [PW-1:0] Q_MIN = -PW'(32768);

  logic                       p_v_r, done_r;
  logic signed [PW-1:0]       prod_r, prod_nxt;
  logic signed [SAMPLE_W-1:0] mix_r, mix_nxt;
  logic [VOL_W-1:0]           gain;
  logic signed [PW-1:0]       sum_x, gain_x, q;

  // Volume above unity acts as unity.
  assign gain   = (vol > VOL_W'(UNITY_GAIN)) ? VOL_W'(UNITY_GAIN) : vol;
  assign sum_x  = PW'(sum);
  assign gain_x = $signed(PW'(gain));
  assign prod_nxt = sum_x * gain_x;

  // Arithmetic shift rounds toward minus infinity.
  assign q = prod_r >>> FRAC_W;

  always_comb begin
    if (q > Q_MAX) begin
      mix_nxt = SAMPLE_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      mix_nxt = SAMPLE_W'(Q_MIN);
    end else begin
      mix_nxt = SAMPLE_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      p_v_r  <= start;
      done_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
    end
    if (p_v_r) begin
      mix_r <= mix_nxt;
    end
  end

  assign done = done_r;
  assign mix  = mix_r;

endmodule

// ===== rtl/voice_mixer_with_allocation.sv =====
// Top level of the voice mixer: sequencer, voice table, sample memory and mix accumulator.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries write, add and tick
// beats; one output channel (out_valid/out_ready/out_data) returns exactly one result
// beat for every input beat, in order. cfg_we/cfg_wdata write the master volume.
// The block works on one beat at a time and drops in_ready while it does.
// Steps from input accept to result valid:
//   write: reciprocal address reduction, then the memory write.
//   add:   reciprocal address reduction, then the voice table is scanned one entry per
//          cycle from voice 0 until a free voice turns up or every voice proves busy.
//          A zero-length add is answered without reduction or scan.
//   tick:  one voice is read, advanced and accumulated per cycle through the voice table
//          port and the sample memory port, then the sum is scaled by the master volume.
// After reset the voice table is cleared one entry per cycle, so in_ready stays low
// until every entry is cleared; the sample memory is not cleared. The master volume resets
// to one half. A result waits in the output register while out_ready is low, and the
// block takes its next beat during that wait, but finishes it only once the
// register is free.
module voice_mixer_with_allocation #(
  parameter int NUM_VOICES       = 32,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vmx_pkg::vmx_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vmx_pkg::vmx_out_t out_data,
  input  logic              cfg_we,
  input  logic [vmx_pkg::VOL_W-1:0] cfg_wdata
);
  import vmx_pkg::*;

  localparam int AW  = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int VCW = $clog2(NUM_VOICES + 1);
  localparam int SW  = SAMPLE_W + $clog2(NUM_VOICES) + 1;

  typedef struct packed {
    logic              active;
    logic [LEN_W-1:0]  remaining;
    logic [ADDR_W-1:0] position;
    logic [AW-1:0]     index;
  } voice_t;

  vmx_state_t        state_r, state_nxt;
  vmx_in_t           req_r, req_nxt;
  vmx_out_t          res_r, res_nxt;
  vmx_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VCW-1:0]    cnt_r, cnt_nxt;
  logic              v1_r, v1_nxt;
  logic [VW-1:0]     v1_idx_r, v1_idx_nxt;
  logic              v2_r, v2_nxt;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [VOL_W-1:0]  vol_r;

  // Voice table and sample memory ports.
  voice_t            vmem [NUM_VOICES];
  voice_t            vrd_r;
  voice_t            vm_wdata, vupd;
  logic              vm_we, vm_re;
  logic [VW-1:0]     vm_waddr;
  logic signed [SAMPLE_W-1:0] smem [SAMPLE_MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] smp_rd_r;
  logic              sm_we, sm_re;
  logic [AW-1:0]     sm_raddr;

  logic              red_start, red_done;
  logic [AW-1:0]     red_rem;
  logic              sc_start, sc_done;
  logic signed [SAMPLE_W-1:0] sc_mix;
  logic              issue_more;

  vmx_addr_reduce #(
    .SAMPLE_MEM_DEPTH(SAMPLE_MEM_DEPTH),
    .AW              (AW)
  ) u_reduce (
    .clk  (clk),
    .rst_n(rst_n),
    .start(red_start),
    .addr (req_nxt.address),
    .done (red_done),
    .rem  (red_rem)
  );

  vmx_scale_clip #(
    .SW(SW)
  ) u_scale (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sc_start),
    .sum  (acc_r),
    .vol  (vol_r),
    .done (sc_done),
    .mix  (sc_mix)
  );

  assign issue_more = (cnt_r < VCW'(NUM_VOICES));

  // Next value of a voice after it plays one sample.
  always_comb begin
    vupd           = vrd_r;
    vupd.position  = ADDR_W'(vrd_r.position + 1'b1);
    if (vrd_r.position == '1 || vrd_r.index == AW'(SAMPLE_MEM_DEPTH - 1)) begin
      vupd.index = '0;
    end else begin
      vupd.index = AW'(vrd_r.index + 1'b1);
    end
    vupd.remaining = (vrd_r.remaining != '0) ? LEN_W'(vrd_r.remaining - 1'b1) : '0;
    vupd.active    = (vupd.remaining != '0);
  end

  // Sequencer: next state, memory controls and result staging.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cnt_nxt       = cnt_r;
    v1_nxt        = 1'b0;
    v1_idx_nxt    = v1_idx_r;
    v2_nxt        = 1'b0;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    vm_we         = 1'b0;
    vm_waddr      = v1_idx_r;
    vm_wdata      = vupd;
    vm_re         = 1'b0;
    sm_we         = 1'b0;
    sm_re         = 1'b0;
    sm_raddr      = vrd_r.index;
    red_start     = 1'b0;
    sc_start      = 1'b0;
    in_ready      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = cnt_r[VW-1:0];
        vm_wdata = '0;
        cnt_nxt  = VCW'(cnt_r + 1'b1);
        if (cnt_r == VCW'(NUM_VOICES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          cnt_nxt = '0;
          acc_nxt = '0;
          case (in_data.action)
            ACT_WRITE: begin
              red_start = 1'b1;
              state_nxt = ST_REDUCE;
            end
            ACT_ADD: begin
              if (in_data.length == '0) begin
                res_nxt.no_free_voice = 1'b1;
                state_nxt             = ST_DONE;
              end else begin
                red_start = 1'b1;
                state_nxt = ST_REDUCE;
              end
            end
            ACT_TICK: begin
              state_nxt = ST_TICK;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_REDUCE: begin
        if (red_done) begin
          idx_nxt   = red_rem;
          state_nxt = (req_r.action == ACT_WRITE) ? ST_WRITE : ST_SCAN;
        end
      end

      ST_WRITE: begin
        sm_we     = 1'b1;
        state_nxt = ST_DONE;
      end

      // Lowest free voice: one table entry checked per cycle.
      ST_SCAN: begin
        if (v1_r && !vrd_r.active) begin
          vm_we                 = 1'b1;
          vm_wdata.active       = 1'b1;
          vm_wdata.remaining    = req_r.length;
          vm_wdata.position     = req_r.address;
          vm_wdata.index        = idx_r;
          res_nxt.voice_number  = VNUM_W'(v1_idx_r);
          state_nxt             = ST_DONE;
        end else if (!issue_more && !v1_r) begin
          res_nxt.no_free_voice = 1'b1;
          state_nxt             = ST_DONE;
        end else if (issue_more) begin
          vm_re      = 1'b1;
          v1_nxt     = 1'b1;
          v1_idx_nxt = cnt_r[VW-1:0];
          cnt_nxt    = VCW'(cnt_r + 1'b1);
        end
      end

      // Read voice, fetch its sample and write it back advanced, then accumulate.
      ST_TICK: begin
        if (issue_more) begin
          vm_re      = 1'b1;
          v1_nxt     = 1'b1;
          v1_idx_nxt = cnt_r[VW-1:0];
          cnt_nxt    = VCW'(cnt_r + 1'b1);
        end
        if (v1_r && vrd_r.active) begin
          vm_we  = 1'b1;
          sm_re  = 1'b1;
          v2_nxt = 1'b1;
        end
        if (v2_r) begin
          acc_nxt = SW'(acc_r + SW'(smp_rd_r));
        end
        if (!issue_more && !v1_r && !v2_r) begin
          sc_start  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end

      ST_SCALE: begin
        if (sc_done) begin
          res_nxt.mixed_sample = sc_mix;
          state_nxt            = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vol_r       <= VOL_W'(VOL_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      if (cfg_we) begin
        vol_r <= cfg_wdata;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
    v1_idx_r <= v1_idx_nxt;
    acc_r    <= acc_nxt;
    idx_r    <= idx_nxt;
  end

  // Voice table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      vrd_r <= vmem[cnt_r[VW-1:0]];
    end
  end

  // Sample memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[idx_r] <= req_r.sample_value;
    end
    if (sm_re) begin
      smp_rd_r <= smem[sm_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/vmx_checker.sv =====
// Port-level checks of the voice mixer, bound to the top level.
module vmx_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input vmx_pkg::vmx_out_t out_data
);
  import vmx_pkg::*;

  // A result beat that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The voice table clear keeps the block busy right after reset.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during voice table clear");

  // One beat at a time: busy in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // A refused add never names a voice, and a claimed voice carries no mix.
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.no_free_voice || out_data.voice_number == '0) &&
                  (out_data.voice_number == '0 || out_data.mixed_sample == '0))
    else $error("inconsistent result fields");

endmodule

bind voice_mixer_with_allocation vmx_checker u_vmx_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== sim/vmx_mix_checker.sv =====
// Checker of the voice mixer: watches both channels, predicts every result beat and compares.
module vmx_mix_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  vmx_pkg::vmx_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  vmx_pkg::vmx_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [vmx_pkg::VOL_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        results_pending,
  output int                        refusals,
  output int                        clipped_mixes
);
  import vmx_pkg::*;

  localparam int VOICES = 32;

  // Predicted state of the block.
  logic signed [SAMPLE_W-1:0] sample_mem [0:65535];
  logic [ADDR_W-1:0]          play_pos [VOICES];
  logic [LEN_W-1:0]           play_left [VOICES];
  logic [VOICES-1:0]          playing;
  logic [VOL_W-1:0]           volume;
  vmx_out_t                   owed_results [$];

  always @(posedge clk) begin : watch
    vmx_out_t predicted;
    vmx_out_t oldest;
    longint   sum;
    longint   gain;
    longint   q;
    int       pick;
    bit       found;

    if (!rst_n) begin
      playing = '0;
      volume  = VOL_W'(VOL_RESET);
      owed_results.delete();
      for (int v = 0; v < VOICES; v++) begin
        play_pos[v]  = '0;
        play_left[v] = '0;
      end
    end else begin
      if (cfg_we) begin
        volume = cfg_wdata;
      end

      // Work out the result of every accepted input beat.
      if (in_valid && in_ready) begin
        predicted = '0;
        case (in_data.action)
          ACT_WRITE: begin
            sample_mem[in_data.address] = in_data.sample_value;
          end
          ACT_ADD: begin
            found = 1'b0;
            pick  = 0;
            for (int v = 0; v < VOICES; v++) begin
              if (!found && !playing[v]) begin
                pick  = v;
                found = 1'b1;
              end
            end
            if (!found || in_data.length == '0) begin
              predicted.no_free_voice = 1'b1;
              refusals++;
            end else begin
              play_pos[pick]         = in_data.address;
              play_left[pick]        = in_data.length;
              playing[pick]          = 1'b1;
              predicted.voice_number = pick[VNUM_W-1:0];
            end
          end
          ACT_TICK: begin
            sum = 0;
            for (int v = 0; v < VOICES; v++) begin
              if (playing[v]) begin
                sum = sum + sample_mem[play_pos[v]];
                play_pos[v] = play_pos[v] + 1'b1;
                if (play_left[v] != '0) begin
                  play_left[v] = play_left[v] - 1'b1;
                end
                if (play_left[v] == '0) begin
                  playing[v] = 1'b0;
                end
              end
            end
            // Gains above unity act as unity; the shift rounds toward minus infinity.
            gain = (volume > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(volume);
            q = (sum * gain) >>> FRAC_W;
            if (q > 32767) begin
              q = 32767;
              clipped_mixes++;
            end else if (q < -32768) begin
              q = -32768;
              clipped_mixes++;
            end
            predicted.mixed_sample = q[SAMPLE_W-1:0];
          end
          default: begin
          end
        endcase
        owed_results.push_back(predicted);
      end

      // Compare every result beat with the oldest prediction.
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result beat arrived with no prediction waiting");
          mismatches++;
        end else begin
          oldest = owed_results.pop_front();
          if (out_data.mixed_sample !== oldest.mixed_sample) begin
            $error("mixed_sample: expected %0d, got %0d", oldest.mixed_sample,
                   out_data.mixed_sample);
            mismatches++;
          end
          if (out_data.voice_number !== oldest.voice_number) begin
            $error("voice_number: expected %0d, got %0d", oldest.voice_number,
                   out_data.voice_number);
            mismatches++;
          end
          if (out_data.no_free_voice !== oldest.no_free_voice) begin
            $error("no_free_voice: expected %0d, got %0d", oldest.no_free_voice,
                   out_data.no_free_voice);
            mismatches++;
          end
        end
      end
    end
    results_pending = owed_results.size();
  end

endmodule

// ===== sim/voice_mixer_with_allocation_tb.sv =====
// Testbench top of the voice mixer: clock, reset, stimulus, idling and the verdict.
module voice_mixer_with_allocation_tb;
  import vmx_pkg::*;

  localparam logic [1:0]        ACT_UNUSED    = 2'd3;
  localparam logic [ADDR_W-1:0] WINDOW_BASE   = 16'hFFF0;
  localparam int                SETTLE_CYCLES = 64;
  localparam int                LONG_HOLD     = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  vmx_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  vmx_out_t          out_data;
  logic              cfg_we;
  logic [VOL_W-1:0]  cfg_wdata;

  int mismatches;
  int results_pending;
  int refusals;
  int clipped_mixes;

  int n_beats;
  int n_write;
  int n_add;
  int n_tick;
  int n_unused;
  bit no_gaps;

  // Every sample a voice may read is written first; the traces follow each add as if
  // it had been granted, which covers every voice that really plays.
  bit                sample_written [0:65535];
  logic [ADDR_W-1:0] trace_pos [$];
  logic [LEN_W-1:0]  trace_left [$];

  voice_mixer_with_allocation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  vmx_mix_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .results_pending (results_pending),
    .refusals        (refusals),
    .clipped_mixes   (clipped_mixes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  // Voices start in one shared window around the address wrap, so their reads overlap.
  function automatic logic [ADDR_W-1:0] voice_start();
    logic [ADDR_W-1:0] offset;
    offset = ADDR_W'($urandom_range(47));
    return WINDOW_BASE + offset;
  endfunction

  function automatic logic [LEN_W-1:0] rand_length(input bit long_bias);
    int          roll;
    logic [31:0] r;
    roll = $urandom_range(99);
    r    = $urandom();
    if (roll < 3) return '0;
    if (roll < 4) return 17'd65536;
    if (roll < 5) return {1'b1, r[15:0]};
    if (roll < 6) return {1'b0, r[15:0]};
    if (long_bias) return LEN_W'($urandom_range(20, 200));
    return LEN_W'($urandom_range(1, 24));
  endfunction

  // Fields that the action ignores still carry random bits.
  function automatic vmx_in_t noise_beat(input logic [1:0] act);
    vmx_in_t     beat;
    logic [31:0] r1;
    logic [31:0] r2;
    r1 = $urandom();
    r2 = $urandom();
    beat.action       = act;
    beat.address      = r1[15:0];
    beat.sample_value = r1[31:16];
    beat.length       = r2[LEN_W-1:0];
    return beat;
  endfunction

  // Offers one beat from a falling edge and returns at the falling edge after acceptance.
  task automatic send_beat(input vmx_in_t beat);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_beats++;
    case (beat.action)
      ACT_WRITE: n_write++;
      ACT_ADD:   n_add++;
      ACT_TICK:  n_tick++;
      default:   n_unused++;
    endcase
    @(negedge clk);
  endtask

  task automatic write_sample(input logic [ADDR_W-1:0] addr,
                              input logic signed [SAMPLE_W-1:0] value);
    vmx_in_t beat;
    beat              = noise_beat(ACT_WRITE);
    beat.address      = addr;
    beat.sample_value = value;
    sample_written[addr] = 1'b1;
    send_beat(beat);
  endtask

  task automatic add_voice(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    vmx_in_t beat;
    beat         = noise_beat(ACT_ADD);
    beat.address = addr;
    beat.length  = len;
    if (len != '0) begin
      trace_pos.push_back(addr);
      trace_left.push_back(len);
    end
    send_beat(beat);
  endtask

  task automatic tick_mix();
    // Fill any sample that a voice could read at this tick.
    foreach (trace_pos[k]) begin
      if (!sample_written[trace_pos[k]]) begin
        write_sample(trace_pos[k], rand_sample());
      end
    end
    send_beat(noise_beat(ACT_TICK));
    for (int k = trace_pos.size() - 1; k >= 0; k--) begin
      trace_pos[k]  = trace_pos[k] + 1'b1;
      trace_left[k] = trace_left[k] - 1'b1;
      if (trace_left[k] == '0) begin
        trace_pos.delete(k);
        trace_left.delete(k);
      end
    end
  endtask

  // Waits until every result is back, then writes the master volume.
  task automatic settle_and_set_volume(input logic [VOL_W-1:0] vol);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= vol;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int beats, input int pct_write, input int pct_add,
                           input int pct_tick, input bit long_bias);
    int          stop_at;
    int          roll;
    logic [31:0] r;
    stop_at = n_beats + beats;
    while (n_beats < stop_at) begin
      roll = $urandom_range(99);
      r    = $urandom();
      if (roll < pct_write) begin
        if (r[31]) begin
          write_sample(voice_start(), rand_sample());
        end else begin
          write_sample(r[15:0], rand_sample());
        end
      end else if (roll < pct_write + pct_add) begin
        add_voice(voice_start(), rand_length(long_bias));
      end else if (roll < pct_write + pct_add + pct_tick) begin
        tick_mix();
      end else begin
        send_beat(noise_beat(ACT_UNUSED));
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the block.
  initial begin : receiver
    int stall;
    int delivered;
    out_ready = 1'b0;
    delivered = 0;
    forever begin
      @(negedge clk);
      stall = no_gaps ? 0 : pick_gap();
      if (delivered == 150) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      delivered++;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    no_gaps   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle_and_set_volume(16'd32768);

    // Directed beats: field extremes, position wrap, zero length, an empty mix,
    // the unused action, lengths of 65536 and above, and clipping both ways.
    write_sample(16'hFFFF, 16'sh7FFF);
    write_sample(16'h0000, 16'sh8000);
    write_sample(16'h0001, 16'sh7FFF);
    add_voice(16'hFFFF, 17'd3);
    add_voice(16'h0000, 17'd0);
    add_voice(16'h0000, 17'd2);
    repeat (4) tick_mix();
    send_beat(noise_beat(ACT_UNUSED));
    add_voice(16'h0001, 17'd65536);
    add_voice(16'h0001, 17'h1FFFF);
    add_voice(16'hFFFF, 17'd1);
    tick_mix();
    write_sample(16'h0002, 16'sh8000);
    add_voice(16'h0000, 17'd2);
    add_voice(16'h0000, 17'd2);
    tick_mix();

    // Random phases, each at its own master volume.
    settle_and_set_volume(16'd32768);
    run_phase(200, 30, 30, 35, 1'b0);
    settle_and_set_volume(16'hFFFF);
    run_phase(200, 15, 55, 27, 1'b1);
    no_gaps = 1'b1;
    settle_and_set_volume(16'd0);
    run_phase(120, 30, 30, 38, 1'b0);
    no_gaps = 1'b0;
    settle_and_set_volume(VOL_W'($urandom_range(1, 32767)));
    run_phase(200, 30, 30, 35, 1'b0);
    settle_and_set_volume(16'd1);
    run_phase(130, 20, 25, 53, 1'b0);

    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d beats: %0d writes, %0d adds, %0d ticks, %0d unused.",
             n_beats, n_write, n_add, n_tick, n_unused);
    $display("Six volume settings from 0 to 65535; %0d adds refused, %0d mixes clipped.",
             refusals, clipped_mixes);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
